### design/cykcr_pkg.sv
// Shared beat types, codes and controller/datapath interface structs.
`timescale 1ns / 1ps
package cykcr_pkg;

	typedef struct packed {
		logic [2:0] action;
		logic [3:0] nonterm;
		logic [3:0] left_sym;
		logic [3:0] right_sym;
		logic [4:0] start_req;
		logic [5:0] length;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic       entry_bit;
	} out_beat_t;

	localparam logic [2:0] ACT_LOAD  = 3'd0;
	localparam logic [2:0] ACT_SET   = 3'd1;
	localparam logic [2:0] ACT_CLEAR = 3'd2;
	localparam logic [2:0] ACT_RUN   = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic CFG_NONTERMS = 1'b0;
	localparam logic CFG_TOKENS   = 1'b1;

	localparam int FIRST_RUN_LEN = 2;

	// controller -> datapath
	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic ent_fin;
		logic row_rd;
		logic row_cap;
		logic fetch;
		logic set_hit;
		logic k_inc;
		logic j_inc;
		logic run_wr;
		logic push;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic entry_ok;
		logic run_go;
		logic skip;
		logic hit;
		logic k_last;
		logic j_last;
		logic run_last;
		logic out_free;
	} flags_t;

endpackage

### design/cykcr_ctrl.sv
// Sequencing state machine for beats, chart clearing and the parse run.
`timescale 1ns / 1ps
module cykcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cykcr_pkg::flags_t flags,
	output cykcr_pkg::cmd_t   cmd
);

	typedef enum logic [8:0] {
		S_CLEAR   = 9'b000000001,
		S_IDLE    = 9'b000000010,
		S_ENT     = 9'b000000100,
		S_DONE    = 9'b000001000,
		S_ROW_RD  = 9'b000010000,
		S_ROW_CAP = 9'b000100000,
		S_FETCH   = 9'b001000000,
		S_EVAL    = 9'b010000000,
		S_WRITE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (flags.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					priority if (flags.entry_ok) state_d = S_ENT;
					else if (flags.run_go)       state_d = S_ROW_RD;
					else                         state_d = S_DONE;
				end
			end
			S_ENT: begin
				cmd.ent_fin = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (flags.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_ROW_RD: begin
				cmd.row_rd = 1'b1;
				state_d    = S_ROW_CAP;
			end
			S_ROW_CAP: begin
				cmd.row_cap = 1'b1;
				state_d     = flags.skip ? S_WRITE : S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				priority if (flags.hit) begin
					cmd.set_hit = 1'b1;
					state_d     = S_WRITE;
				end else if (!flags.k_last) begin
					cmd.k_inc = 1'b1;
					state_d   = S_FETCH;
				end else if (!flags.j_last) begin
					cmd.j_inc = 1'b1;
					state_d   = S_FETCH;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.run_wr = 1'b1;
				state_d    = flags.run_last ? S_DONE : S_ROW_RD;
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

### design/cykcr_datapath.sv
// Chart and rule memories, loop counters, config registers and result registers.
`timescale 1ns / 1ps
module cykcr_datapath #(
	parameter int NONTERMS     = 16,
	parameter int RULES_PER_NT = 8,
	parameter int TOKENS       = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cykcr_pkg::in_beat_t  in_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_index,
	input  logic [5:0]           cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output cykcr_pkg::out_beat_t out_data,
	input  cykcr_pkg::cmd_t      cmd,
	output cykcr_pkg::flags_t    flags
);

	localparam int ROW_SPAN = TOKENS + 1;
	localparam int DEPTH    = TOKENS * ROW_SPAN;
	localparam int AW       = $clog2(DEPTH);
	localparam int NTW      = $clog2(NONTERMS);
	localparam int NW       = $clog2(NONTERMS + 1);
	localparam int TW       = $clog2(TOKENS);
	localparam int LW       = $clog2(TOKENS + 1);
	localparam int JW       = (RULES_PER_NT > 1) ? $clog2(RULES_PER_NT) : 1;
	localparam int CW       = $clog2(RULES_PER_NT + 1);
	localparam int RDEPTH   = NONTERMS * RULES_PER_NT;
	localparam int RAW      = $clog2(RDEPTH);

	function automatic logic [AW-1:0] row_addr(input logic [TW-1:0] st,
			input logic [LW-1:0] ln);
		row_addr = AW'(int'(st) * ROW_SPAN + int'(ln));
	endfunction

	// memories
	logic [NONTERMS-1:0] chart_mem [DEPTH];
	logic [2*NTW-1:0]    rule_mem  [RDEPTH];
	logic [CW-1:0]       cnt_q     [NONTERMS];

	logic [NONTERMS-1:0] rd_a_q, rd_b_q, row_q, wdata;
	logic [2*NTW-1:0]    rule_q;
	logic [AW-1:0]       addr_a, addr_b, waddr;
	logic                we;
	logic [RAW-1:0]      raddr;

	// config
	logic [4:0] used_nonterms_q;
	logic [5:0] used_tokens_q;
	logic [NW-1:0] n_eff;
	logic [LW-1:0] m_eff;

	// loop state
	logic [LW-1:0]  l_q, k_q;
	logic [NTW-1:0] nt_q;
	logic [TW-1:0]  i_q;
	logic [JW-1:0]  j_q;
	logic           val_q;
	logic [AW-1:0]  clr_q;

	cykcr_pkg::in_beat_t  req_q;
	cykcr_pkg::out_beat_t res_q, res_d;

	logic [NTW-1:0] in_nt, req_nt;
	logic [CW-1:0]  in_cnt, run_cnt;
	logic           is_entry, entry_bad, rule_bad, rule_full, load_ok;

	assign n_eff = (used_nonterms_q > NONTERMS) ? NW'(NONTERMS) : NW'(used_nonterms_q);
	assign m_eff = (used_tokens_q > TOKENS) ? LW'(TOKENS) : LW'(used_tokens_q);

	assign in_nt   = NTW'(in_data.nonterm);
	assign req_nt  = NTW'(req_q.nonterm);
	assign in_cnt  = cnt_q[in_nt];
	assign run_cnt = cnt_q[nt_q];

	// beat decode
	assign is_entry = (in_data.action == cykcr_pkg::ACT_SET)
		|| (in_data.action == cykcr_pkg::ACT_CLEAR)
		|| (in_data.action == cykcr_pkg::ACT_READ);
	assign entry_bad = (in_data.nonterm >= n_eff) || (in_data.start_req >= m_eff)
		|| (in_data.length > m_eff);
	assign rule_bad = (in_data.nonterm == 4'd0) || (in_data.nonterm >= n_eff)
		|| (in_data.left_sym >= n_eff) || (in_data.right_sym >= n_eff);
	assign rule_full = (in_cnt >= RULES_PER_NT);
	assign load_ok   = (in_data.action == cykcr_pkg::ACT_LOAD) && !rule_bad && !rule_full;

	always_comb begin
		res_d = '0;
		unique case (in_data.action)
			cykcr_pkg::ACT_LOAD: begin
				priority if (rule_bad) res_d.status = cykcr_pkg::ST_RANGE;
				else if (rule_full)    res_d.status = cykcr_pkg::ST_FULL;
				else                   res_d.status = cykcr_pkg::ST_OK;
			end
			cykcr_pkg::ACT_SET, cykcr_pkg::ACT_CLEAR, cykcr_pkg::ACT_READ:
				res_d.status = entry_bad ? cykcr_pkg::ST_RANGE : cykcr_pkg::ST_OK;
			cykcr_pkg::ACT_RUN: res_d.status = cykcr_pkg::ST_OK;
			default: res_d.status = cykcr_pkg::ST_RANGE;
		endcase
	end

	// chart ports
	always_comb begin
		priority if (cmd.fetch) addr_a = row_addr(i_q, k_q);
		else if (cmd.row_rd)    addr_a = row_addr(i_q, l_q);
		else                    addr_a = row_addr(TW'(in_data.start_req), LW'(in_data.length));
	end
	assign addr_b = row_addr(TW'(i_q + k_q), l_q - k_q);

	always_comb begin
		we    = 1'b0;
		waddr = row_addr(i_q, l_q);
		wdata = row_q;
		priority if (cmd.clr_wr) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (cmd.ent_fin) begin
			we    = (req_q.action != cykcr_pkg::ACT_READ);
			waddr = row_addr(TW'(req_q.start_req), LW'(req_q.length));
			wdata = rd_a_q;
			wdata[req_nt] = (req_q.action == cykcr_pkg::ACT_SET);
		end else if (cmd.run_wr) begin
			we = 1'b1;
			wdata[nt_q] = val_q;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) chart_mem[waddr] <= wdata;
		rd_a_q <= chart_mem[addr_a];
		rd_b_q <= chart_mem[addr_b];
	end

	// rule store: written on load, read at the current (nt, j) slot
	assign raddr = RAW'(int'(nt_q) * RULES_PER_NT + int'(j_q));
	always_ff @(posedge clk) begin
		if (cmd.accept && load_ok) begin
			rule_mem[RAW'(int'(in_nt) * RULES_PER_NT + int'(in_cnt))] <=
				{NTW'(in_data.left_sym), NTW'(in_data.right_sym)};
		end
		rule_q <= rule_mem[raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_nonterms_q <= 5'd16;
			used_tokens_q   <= 6'd32;
			clr_q           <= '0;
			out_valid       <= 1'b0;
			for (int n = 0; n < NONTERMS; n++) cnt_q[n] <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					cykcr_pkg::CFG_NONTERMS: used_nonterms_q <= cfg_data[4:0];
					cykcr_pkg::CFG_TOKENS:   used_tokens_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.accept && load_ok) cnt_q[in_nt] <= in_cnt + 1'b1;
			if (cmd.push)          out_valid <= 1'b1;
			else if (out_ready)    out_valid <= 1'b0;
		end
	end

	// payload and loop registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= in_data;
			res_q <= res_d;
			l_q   <= LW'(cykcr_pkg::FIRST_RUN_LEN);
			nt_q  <= NTW'(1);
			i_q   <= '0;
		end
		if (cmd.ent_fin && req_q.action == cykcr_pkg::ACT_READ) res_q.entry_bit <= rd_a_q[req_nt];
		if (cmd.row_cap) begin
			row_q <= rd_a_q;
			val_q <= 1'b0;
			j_q   <= '0;
			k_q   <= LW'(1);
		end
		if (cmd.set_hit) val_q <= 1'b1;
		if (cmd.k_inc)   k_q   <= k_q + 1'b1;
		if (cmd.j_inc) begin
			j_q <= j_q + 1'b1;
			k_q <= LW'(1);
		end
		if (cmd.run_wr) begin
			if (!flags.run_last) begin
				priority if ((i_q + l_q) < m_eff) begin
					i_q <= i_q + 1'b1;
				end else if (!((nt_q + 1'b1) >= n_eff)) begin
					i_q  <= '0;
					nt_q <= nt_q + 1'b1;
				end else begin
					i_q  <= '0;
					nt_q <= NTW'(1);
					l_q  <= l_q + 1'b1;
				end
			end
		end
		if (cmd.push) out_data <= res_q;
	end

	// status to the controller
	assign flags.clr_last = (clr_q == AW'(DEPTH - 1));
	assign flags.entry_ok = is_entry && !entry_bad;
	assign flags.run_go   = (in_data.action == cykcr_pkg::ACT_RUN)
		&& (m_eff >= cykcr_pkg::FIRST_RUN_LEN) && (n_eff >= cykcr_pkg::FIRST_RUN_LEN);
	assign flags.skip     = rd_a_q[nt_q] || (run_cnt == '0);
	assign flags.hit      = rd_a_q[rule_q[2*NTW-1:NTW]] && rd_b_q[rule_q[NTW-1:0]];
	assign flags.k_last   = ((k_q + 1'b1) >= l_q);
	assign flags.j_last   = ((j_q + 1'b1) >= run_cnt);
	assign flags.run_last = ((i_q + l_q) >= m_eff) && ((nt_q + 1'b1) >= n_eff)
		&& (l_q >= m_eff);
	assign flags.out_free = !out_valid || out_ready;

endmodule

### design/cyk_chart_recognizer_unit.sv
// Top level of the CYK chart recognizer: controller, datapath and checks.
`timescale 1ns / 1ps
// CYK recognizer for binary rules A -> B C over a chart of TOKENS*(TOKENS+1)
// rows, one bit per nonterminal in each row. After reset the chart is swept
// to zero, one row per cycle; in_ready stays low during the sweep, config
// writes are taken throughout. One beat at a time is worked: a rule load, a
// bad index, an unknown action or a run that cannot start goes from accept
// to the done state; set/clear/read pass the entry state first (one chart
// read, then write or bit select). A run walks each (length, nonterminal,
// start) entry from length 2 and nonterminal 1 up: row read, row capture,
// a fetch and evaluate per (rule, split) pair tried until the first match,
// then a write. Every beat yields one result beat; the result register lets
// the next beat be taken while the last result waits.
module cyk_chart_recognizer_unit #(
	parameter int NONTERMS     = 16,
	parameter int RULES_PER_NT = 8,
	parameter int TOKENS       = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cykcr_pkg::in_beat_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cykcr_pkg::out_beat_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [5:0]           cfg_data
);

	cykcr_pkg::cmd_t   cmd;
	cykcr_pkg::flags_t flags;

	// config registers are plain flops: always ready
	assign cfg_ready = 1'b1;

	cykcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.flags    (flags),
		.cmd      (cmd)
	);

	cykcr_datapath #(
		.NONTERMS     (NONTERMS),
		.RULES_PER_NT (RULES_PER_NT),
		.TOKENS       (TOKENS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.flags     (flags)
	);

	// one beat in flight: an accept is never followed by another right away
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted on back-to-back cycles");

	// a set chart bit is only returned with ok status
	a_bit_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.entry_bit) |-> (out_data.status == cykcr_pkg::ST_OK))
		else $error("entry bit set on a failed beat");

	// a result is only loaded when the output register is free
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid || out_ready))
		else $error("result overwritten before it was taken");

	// after a result is loaded the controller is back in idle, with no second load
	a_push_idle_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (in_ready && !cmd.push))
		else $error("controller did not return to idle after a result");

endmodule
